// File: rtl/core/skvt_pkg.sv
// Package for the sorted key/value table: sizes, operation and status codes,
// and the control struct that the sequencer broadcasts to every cell.
// No dependencies.
`timescale 1ns / 1ps

package skvt_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // entry count must hold CAPACITY itself
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // hit/value reduction: cells are ORed in groups, groups in a second stage
    localparam int GROUP_SIZE = 16;
    localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_CELLS  = GROUPS * GROUP_SIZE;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_DELETE  = 2'd2,
        OP_REPLACE = 2'd3
    } op_e;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISSING   = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic compare;   // latch lt/eq flags against the command key
        logic insert;    // open a slot at the insert point, shift up
        logic remove;    // close the slot of the hit, shift down
        logic replace;   // overwrite the value of the hit cell
    } cell_ctrl_t;

endpackage

// File: rtl/core/sorted_key_value_table.sv
// Top level of the sorted key/value table: command sequencer, cell chain and
// two-stage hit/value reduction.
// Depends on skvt_pkg and skvt_cell.
//
//  channel   | handshake      | beat fields
//  ----------+----------------+-------------------------------------
//  command   | start / busy   | op, key, value
//  result    | strobe         | status, found_value, entry_count
//
// Every command runs from acceptance to its result strobe through the states
// S_CMP, where all cells compare against the key, S_REDUCE, where the first
// OR stage gathers the hit flag and hit value per group, and S_COMMIT, where
// the second OR stage runs together with the shift and count update; the
// strobe follows. busy is high in S_CMP, S_REDUCE and S_COMMIT; a new command
// can be taken in the cycle the previous result is strobed.
// Reset clears the sequencer, the entry count and the strobe; slot contents
// are not cleared, empty slots are masked by the entry count.
// The result strobe is high for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps

module sorted_key_value_table (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             op,
    input  logic signed [skvt_pkg::KEY_BITS-1:0]   key,
    input  logic        [skvt_pkg::VALUE_BITS-1:0] value,
    output logic                                   strobe,
    output logic [1:0]                             status,
    output logic [skvt_pkg::VALUE_BITS-1:0]        found_value,
    output logic [skvt_pkg::CNT_W-1:0]             entry_count
);
    import skvt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_REDUCE,
        S_COMMIT
    } state_t;

    state_t                 state_reg;
    logic                   accept;

    // latched command
    op_e                    cmd_op_reg;
    logic signed [KEY_BITS-1:0] cmd_key_reg;
    logic [VALUE_BITS-1:0]  cmd_value_reg;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [VALUE_BITS-1:0]  found_reg;
    logic [VALUE_BITS-1:0]  found_next;
    logic                   strobe_reg;

    cell_ctrl_t             ctrl;

    // cell chain taps; the eq and hit taps are padded to a whole number of groups
    logic                   cell_lt  [CAPACITY];
    logic signed [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [VALUE_BITS-1:0]  cell_val [CAPACITY];
    logic                   cell_eq  [PAD_CELLS];
    logic [VALUE_BITS-1:0]  cell_hit [PAD_CELLS];

    // first reduction stage
    logic                   grp_hit_reg  [GROUPS];
    logic [VALUE_BITS-1:0]  grp_val_reg  [GROUPS];
    logic                   grp_hit_next [GROUPS];
    logic [VALUE_BITS-1:0]  grp_val_next [GROUPS];

    logic                   hit;
    logic [VALUE_BITS-1:0]  hit_val;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg    <= op_e'(op);
            cmd_key_reg   <= key;
            cmd_value_reg <= value;
        end
    end

    // ---------------- cell chain ----------------
    genvar i;
    generate
        for (i = 0; i < PAD_CELLS; i++)
        begin : g_cell
            if (i < CAPACITY)
            begin : g_real
                logic                       occ;
                logic                       l_lt;
                logic signed [KEY_BITS-1:0] l_key;
                logic [VALUE_BITS-1:0]      l_val;
                logic signed [KEY_BITS-1:0] r_key;
                logic [VALUE_BITS-1:0]      r_val;

                assign occ = (CNT_W'(i) < count_reg);

                if (i == 0)
                begin : g_first
                    // nothing sits left of slot 0: the insert point may be here
                    assign l_lt  = 1'b1;
                    assign l_key = cmd_key_reg;
                    assign l_val = cmd_value_reg;
                end
                else
                begin : g_mid
                    assign l_lt  = cell_lt[i-1];
                    assign l_key = cell_key[i-1];
                    assign l_val = cell_val[i-1];
                end

                if (i == CAPACITY - 1)
                begin : g_last
                    assign r_key = cell_key[i];
                    assign r_val = cell_val[i];
                end
                else
                begin : g_inner
                    assign r_key = cell_key[i+1];
                    assign r_val = cell_val[i+1];
                end

                skvt_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occupied    (occ),
                    .cmd_key     (cmd_key_reg),
                    .cmd_value   (cmd_value_reg),
                    .left_lt     (l_lt),
                    .left_key    (l_key),
                    .left_value  (l_val),
                    .right_key   (r_key),
                    .right_value (r_val),
                    .lt          (cell_lt[i]),
                    .eq          (cell_eq[i]),
                    .key_out     (cell_key[i]),
                    .value_out   (cell_val[i]),
                    .hit_value   (cell_hit[i])
                );
            end
            else
            begin : g_pad
                assign cell_eq[i]  = 1'b0;
                assign cell_hit[i] = '0;
            end
        end
    endgenerate

    // ---------------- hit / value reduction ----------------
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_hit_next[g] = 1'b0;
            grp_val_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                grp_hit_next[g] = grp_hit_next[g] | cell_eq[g*GROUP_SIZE + j];
                grp_val_next[g] = grp_val_next[g] | cell_hit[g*GROUP_SIZE + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REDUCE)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                grp_hit_reg[g] <= grp_hit_next[g];
                grp_val_reg[g] <= grp_val_next[g];
            end
        end
    end

    // keys are unique, so at most one group carries a hit
    always_comb
    begin
        hit     = 1'b0;
        hit_val = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            hit     = hit | grp_hit_reg[g];
            hit_val = hit_val | grp_val_reg[g];
        end
    end

    // ---------------- commit decision ----------------
    always_comb
    begin
        ctrl        = '0;
        status_next = ST_OK;
        found_next  = '0;
        count_next  = count_reg;

        ctrl.compare = (state_reg == S_CMP);

        if (state_reg == S_COMMIT)
        begin
            case (cmd_op_reg)
                OP_INSERT:
                begin
                    if (hit)
                        status_next = ST_DUPLICATE;
                    else if (count_reg == CNT_W'(CAPACITY))
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit)
                        found_next = hit_val;
                    else
                        status_next = ST_MISSING;
                end
                OP_DELETE:
                begin
                    if (hit)
                    begin
                        ctrl.remove = 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                    else
                        status_next = ST_MISSING;
                end
                OP_REPLACE:
                begin
                    if (hit)
                        ctrl.replace = 1'b1;
                    else
                        status_next = ST_MISSING;
                end
                default:
                begin
                    status_next = ST_MISSING;
                end
            endcase
        end
    end

    // ---------------- sequencer and result registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    state_reg <= S_REDUCE;
                end
                S_REDUCE:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    state_reg  <= S_IDLE;
                    count_reg  <= count_next;
                    status_reg <= status_next;
                    found_reg  <= found_next;
                    strobe_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign entry_count = count_reg;

endmodule

// File: rtl/core/skvt_cell.sv
// One slot of the sorted table: holds a key/value pair, compares it with the
// broadcast command key and shifts to or from its neighbors.
// Depends on skvt_pkg.
`timescale 1ns / 1ps

module skvt_cell (
    input  logic                                clk,
    input  skvt_pkg::cell_ctrl_t                ctrl,
    input  logic                                occupied,
    input  logic signed [skvt_pkg::KEY_BITS-1:0]   cmd_key,
    input  logic        [skvt_pkg::VALUE_BITS-1:0] cmd_value,
    input  logic                                left_lt,
    input  logic signed [skvt_pkg::KEY_BITS-1:0]   left_key,
    input  logic        [skvt_pkg::VALUE_BITS-1:0] left_value,
    input  logic signed [skvt_pkg::KEY_BITS-1:0]   right_key,
    input  logic        [skvt_pkg::VALUE_BITS-1:0] right_value,
    output logic                                lt,
    output logic                                eq,
    output logic signed [skvt_pkg::KEY_BITS-1:0]   key_out,
    output logic        [skvt_pkg::VALUE_BITS-1:0] value_out,
    output logic        [skvt_pkg::VALUE_BITS-1:0] hit_value
);
    import skvt_pkg::*;

    logic signed [KEY_BITS-1:0]   key_reg;
    logic        [VALUE_BITS-1:0] value_reg;
    logic                         lt_reg;
    logic                         eq_reg;
    logic        [VALUE_BITS-1:0] hit_value_reg;
    logic                         lt_now;
    logic                         eq_now;

    assign lt_now = occupied && (key_reg < cmd_key);
    assign eq_now = occupied && (key_reg == cmd_key);

    always_ff @(posedge clk)
    begin
        if (ctrl.compare)
        begin
            lt_reg        <= lt_now;
            eq_reg        <= eq_now;
            hit_value_reg <= eq_now ? value_reg : '0;
        end

        if (ctrl.insert && !lt_reg)
        begin
            // first cell at or above the new key takes it, the rest shift up
            if (left_lt)
            begin
                key_reg   <= cmd_key;
                value_reg <= cmd_value;
            end
            else
            begin
                key_reg   <= left_key;
                value_reg <= left_value;
            end
        end
        else if (ctrl.remove && !lt_reg)
        begin
            key_reg   <= right_key;
            value_reg <= right_value;
        end
        else if (ctrl.replace && eq_reg)
        begin
            value_reg <= cmd_value;
        end
    end

    assign lt        = lt_reg;
    assign eq        = eq_reg;
    assign key_out   = key_reg;
    assign value_out = value_reg;
    assign hit_value = hit_value_reg;

endmodule

// File: rtl/core/skvt_checker.sv
// Port-level checker for the sorted key/value table, bound to the top level.
// Depends on skvt_pkg and sorted_key_value_table.
`timescale 1ns / 1ps

module skvt_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   strobe,
    input logic [1:0]                             status,
    input logic [skvt_pkg::VALUE_BITS-1:0]        found_value,
    input logic [skvt_pkg::CNT_W-1:0]             entry_count
);
    import skvt_pkg::*;

    // every accepted command yields its result strobe after the compare, reduce and commit states
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 strobe)
        else $error("result strobe missing four cycles after command");

    // results are single-cycle beats
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held longer than one cycle");

    // a returned value implies success
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (found_value != '0)) |-> (status == ST_OK))
        else $error("found value on a failed command");

    // count never exceeds the table size
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // count moves only with a result
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!strobe && rst_n && $past(rst_n)) |-> $stable(entry_count))
        else $error("entry count changed without a result");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count)
);
